### hw/rtl/rlbp_pkg.sv
`timescale 1ns / 1ps

package rlbp_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_LINES_DEF  = 128;
    localparam int MAX_DIGITS_DEF = 3;

    // Fixed field widths.
    localparam int CHAR_W   = 8;
    localparam int NUM_W    = 10;
    localparam int CNT_W    = 2;
    localparam int HALF_W   = 64;
    localparam int LINES_W  = 2 * HALF_W;
    localparam int STATUS_W = 3;
    localparam int OUT_PAD  = 5;
    localparam int OUT_W    = LINES_W + STATUS_W + OUT_PAD;

    // Characters that the parser recognizes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;

    // Status codes; the first error of a list is kept.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_DASH     = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // One input item.
    typedef struct packed {
        logic              end_of_string;
        logic [CHAR_W-1:0] char_code;
    } in_item_t;

    // One result item, lines_low in the lowest bits.
    typedef struct packed {
        status_t           status;
        logic [HALF_W-1:0] lines_high;
        logic [HALF_W-1:0] lines_low;
    } result_t;

endpackage

### hw/rtl/range_list_to_bitmap_parser.sv
`timescale 1ns / 1ps

// Channel  Direction  Signals                                   Content
// s_axis   in         tvalid tready tdata[7:0] tlast            one list character
// m_axis   out        tvalid tready tdata[135:0]                bitmap and status
//
// One item is accepted per cycle unless an end-of-list item waits for room in
// the output register. A character is parsed in the cycle after it is accepted;
// the end-of-list item puts its result in the output register. The single parser
// state loop sets this rate. Reset clears the parser state and both valid flags.
// A stalled output holds back only an end-of-list item; characters ahead of it keep flowing.
module range_list_to_bitmap_parser
    import rlbp_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [CHAR_W-1:0]   s_axis_tdata,   // char_code[7:0]
    input  logic                s_axis_tlast,   // end_of_string
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata    // lines_low[63:0], lines_high[127:64],
                                                // status[130:128], zero pad[135:131]
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     take;
    logic     can_load;
    logic     res_valid;
    result_t  res;
    result_t  out_res;

    assign in_item.char_code     = s_axis_tdata;
    assign in_item.end_of_string = s_axis_tlast;

    // An end-of-list item waits until the output register has room.
    assign take = item_valid && (!item.end_of_string || can_load);

    rlbp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rlbp_core #(
        .NUM_LINES  (NUM_LINES),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rlbp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_res};

endmodule

### hw/rtl/rlbp_in_reg.sv
`timescale 1ns / 1ps

module rlbp_in_reg
    import rlbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A new item may enter when the register is empty or is being consumed.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded on every accepted item.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/rlbp_core.sv
`timescale 1ns / 1ps

module rlbp_core
    import rlbp_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    localparam logic [NUM_W-1:0] LINE_LIMIT  = NUM_W'(NUM_LINES);
    localparam logic [CNT_W-1:0] DIGIT_LIMIT = CNT_W'(MAX_DIGITS);

    logic [NUM_LINES-1:0] bitmap_reg, bitmap_next;
    logic [NUM_W-1:0]     number_reg, number_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_W-1:0]     start_reg, start_next;
    logic                 in_range_reg, in_range_next;
    status_t              error_reg, error_next;

    logic                 is_digit;
    logic [NUM_W-1:0]     acc;
    status_t              close_err;
    logic                 set_en;
    logic [NUM_W-1:0]     lo;
    logic [NUM_LINES-1:0] mask;
    status_t              final_err;
    logic [NUM_LINES-1:0] final_bitmap;
    logic [LINES_W-1:0]   lines_all;

    // Character decode and decimal accumulation (times ten as two shifts).
    assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
    assign acc = NUM_W'({number_reg, 3'b000}) + NUM_W'({number_reg, 1'b0})
               + NUM_W'(item.char_code[3:0]);

    // Closing the current token: error check and which lines it selects.
    always_comb
    begin
        close_err = ST_OK;
        set_en    = 1'b0;
        lo        = in_range_reg ? start_reg : number_reg;
        if (in_range_reg)
        begin
            if (count_reg == '0)
            begin
                close_err = ST_DASH;
            end
            else if (start_reg <= number_reg)
            begin
                if (number_reg >= LINE_LIMIT)
                begin
                    close_err = ST_RANGE;
                end
                else
                begin
                    set_en = 1'b1;
                end
            end
        end
        else if (count_reg != '0)
        begin
            if (number_reg >= LINE_LIMIT)
            begin
                close_err = ST_RANGE;
            end
            else
            begin
                set_en = 1'b1;
            end
        end
    end

    // Range mask: one compare pair for each line.
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            mask[i] = set_en && (NUM_W'(i) >= lo) && (NUM_W'(i) <= number_reg);
        end
    end

    // Result of the list when the end marker arrives.
    assign final_err    = (error_reg != ST_OK) ? error_reg : close_err;
    assign final_bitmap = bitmap_reg | mask;
    assign lines_all    = (final_err == ST_OK) ? LINES_W'(final_bitmap) : '0;

    assign res_valid      = fire && item.end_of_string;
    assign res.lines_low  = lines_all[HALF_W-1:0];
    assign res.lines_high = lines_all[LINES_W-1:HALF_W];
    assign res.status     = final_err;

    // Parser state update for one item.
    always_comb
    begin
        bitmap_next   = bitmap_reg;
        number_next   = number_reg;
        count_next    = count_reg;
        start_next    = start_reg;
        in_range_next = in_range_reg;
        error_next    = error_reg;
        if (fire)
        begin
            if (item.end_of_string)
            begin
                bitmap_next   = '0;
                number_next   = '0;
                count_next    = '0;
                start_next    = '0;
                in_range_next = 1'b0;
                error_next    = ST_OK;
            end
            else if (error_reg == ST_OK)
            begin
                if (is_digit)
                begin
                    if (count_reg >= DIGIT_LIMIT)
                    begin
                        error_next = ST_TOO_LONG;
                    end
                    else
                    begin
                        number_next = acc;
                        count_next  = count_reg + 1'b1;
                    end
                end
                else if (item.char_code == CHAR_DASH)
                begin
                    if ((count_reg == '0) || in_range_reg)
                    begin
                        error_next = ST_DASH;
                    end
                    else
                    begin
                        start_next    = number_reg;
                        in_range_next = 1'b1;
                        number_next   = '0;
                        count_next    = '0;
                    end
                end
                else if (item.char_code == CHAR_COMMA)
                begin
                    error_next    = close_err;
                    bitmap_next   = final_bitmap;
                    number_next   = '0;
                    count_next    = '0;
                    start_next    = '0;
                    in_range_next = 1'b0;
                end
                else
                begin
                    error_next = ST_BAD_CHAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg   <= '0;
            number_reg   <= '0;
            count_reg    <= '0;
            start_reg    <= '0;
            in_range_reg <= 1'b0;
            error_reg    <= ST_OK;
        end
        else
        begin
            bitmap_reg   <= bitmap_next;
            number_reg   <= number_next;
            count_reg    <= count_next;
            start_reg    <= start_next;
            in_range_reg <= in_range_next;
            error_reg    <= error_next;
        end
    end

    // A failed list never reports selected lines.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status != ST_OK) |-> (res.lines_low == '0) && (res.lines_high == '0))
        else $error("lines reported with an error status");

    // The end marker returns the whole parser to its empty state.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (bitmap_reg == '0) && (count_reg == '0) && !in_range_reg
                      && (error_reg == ST_OK))
        else $error("parser state not cleared after end of list");

    // The first error is kept until the end of the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg != ST_OK) && !res_valid |=> (error_reg == $past(error_reg)))
        else $error("error code changed within a list");

    // The digit counter never passes the digit limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DIGIT_LIMIT)
        else $error("digit count beyond limit");

endmodule

### hw/rtl/rlbp_out_reg.sv
`timescale 1ns / 1ps

module rlbp_out_reg
    import rlbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register takes a result when empty or when its item leaves this cycle.
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = res_valid ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rlbp_pkg::*;

    localparam int LINE_COUNT = NUM_LINES_DEF;
    localparam int DIGIT_LIMIT = MAX_DIGITS_DEF;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CHAR_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    // Parser state as seen by the prediction.
    logic [LINES_W-1:0]  line_map;
    logic [NUM_W-1:0]    num_acc;
    logic [CNT_W-1:0]    num_digits;
    logic [NUM_W-1:0]    span_first;
    logic                span_open;
    status_t             first_error;

    // Bitmap results still to come out of the block, oldest first.
    result_t             pending_maps[$];

    int                  mismatch_count = 0;
    int                  chars_sent = 0;
    int                  hold_cycles = 0;
    bit                  sender_idles = 1'b1;
    bit                  sink_idles = 1'b1;

    range_list_to_bitmap_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Return the token state to empty.
    function automatic void clear_token();
        num_acc = '0;
        num_digits = '0;
        span_first = '0;
        span_open = 1'b0;
    endfunction

    // Clear everything at the start of a new list.
    function automatic void clear_list();
        line_map = '0;
        clear_token();
        first_error = ST_OK;
    endfunction

    // A comma or the end of the list closes the current token.
    function automatic void close_token();
        if (span_open)
        begin
            if (num_digits == 0)
                first_error = ST_DASH;
            else if (span_first <= num_acc)
            begin
                if (num_acc >= LINE_COUNT)
                    first_error = ST_RANGE;
                else
                    for (int i = span_first; i <= num_acc; i++)
                        line_map[i] = 1'b1;
            end
        end
        else if (num_digits != 0)
        begin
            if (num_acc >= LINE_COUNT)
                first_error = ST_RANGE;
            else
                line_map[num_acc] = 1'b1;
        end
        clear_token();
    endfunction

    // Predict the effect of one accepted item and queue the bitmap it emits.
    function automatic void parse_char(input logic [CHAR_W-1:0] ch, input logic eos);
        result_t res;
        if (!eos)
        begin
            if (first_error != ST_OK)
                return;
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            begin
                if (num_digits >= DIGIT_LIMIT)
                    first_error = ST_TOO_LONG;
                else
                begin
                    num_acc = NUM_W'(num_acc * 10 + (ch - CHAR_ZERO));
                    num_digits = num_digits + 1'b1;
                end
            end
            else if (ch == CHAR_DASH)
            begin
                if (num_digits == 0 || span_open)
                    first_error = ST_DASH;
                else
                begin
                    span_first = num_acc;
                    span_open = 1'b1;
                    num_acc = '0;
                    num_digits = '0;
                end
            end
            else if (ch == CHAR_COMMA)
                close_token();
            else
                first_error = ST_BAD_CHAR;
            return;
        end
        if (first_error == ST_OK)
            close_token();
        res.status = first_error;
        if (first_error == ST_OK)
        begin
            res.lines_low = line_map[HALF_W-1:0];
            res.lines_high = line_map[LINES_W-1:HALF_W];
        end
        else
        begin
            res.lines_low = '0;
            res.lines_high = '0;
        end
        pending_maps.push_back(res);
        clear_list();
    endfunction

    // Offer one item, with an occasional gap before it, and wait for acceptance.
    task automatic send_item(input logic [CHAR_W-1:0] ch, input logic eos);
        while (sender_idles && $urandom_range(0, 99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        chars_sent++;
        parse_char(ch, eos);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b0);
    endtask

    // The character beside the end flag is ignored, so it is random.
    task automatic end_list();
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // Check each bitmap result against the oldest prediction; the sink stalls at random.
    initial
    begin
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[LINES_W+STATUS_W-1:0]);
                if (pending_maps.size() == 0)
                    report_mismatch($sformatf("result with none expected: %h", m_axis_tdata));
                else
                begin
                    want = pending_maps.pop_front();
                    if (got.lines_low !== want.lines_low)
                        report_mismatch($sformatf("lines_low %h, expected %h",
                                                  got.lines_low, want.lines_low));
                    if (got.lines_high !== want.lines_high)
                        report_mismatch($sformatf("lines_high %h, expected %h",
                                                  got.lines_high, want.lines_high));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(sink_idles && $urandom_range(0, 99) < 9);
        end
    end

    // Extremes of the fields and each special case of the parser.
    task automatic test_directed();
        send_text("0-127");
        send_item(8'hFF, 1'b1);
        // Empty tokens and a reversed range select nothing.
        send_text("9-3,,");
        end_list();
        // Dash with no number in front.
        send_text("-");
        end_list();
        // Second dash in one token.
        send_text("1--");
        end_list();
        // Range with no number after the dash.
        send_text("7-");
        end_list();
        // Fourth digit.
        send_text("1000");
        end_list();
        // Bad character; the dash that follows must not replace its code.
        send_item(8'h00, 1'b0);
        send_text("-");
        end_list();
        // Single line just past the bitmap.
        send_text("128");
        end_list();
    endtask

    // Sink holds off for a long stretch while lists keep coming.
    task automatic test_stall_pressure();
        hold_cycles = 300;
        for (int n = 0; n < 5; n++)
        begin
            send_text($sformatf("%0d,%0d-%0d", n, 10 * n, 10 * n + 20));
            end_list();
        end
    endtask

    // Decimal number, sometimes with leading zeros up to the digit limit.
    function automatic string number_text(input int value);
        string txt;
        txt = $sformatf("%0d", value);
        while (txt.len() < DIGIT_LIMIT && $urandom_range(0, 3) == 0)
            txt = {"0", txt};
        return txt;
    endfunction

    function automatic int pick_line();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, LINE_COUNT - 1);
        return $urandom_range(0, 999);
    endfunction

    // Mostly well-formed lists with random lines, some broken ones and noise.
    task automatic test_random(input int item_goal);
        int list_no;
        int tokens;
        int kind;
        int a;
        int b;
        list_no = 0;
        while (chars_sent < item_goal)
        begin
            // One long stretch with no idling on either side.
            sender_idles = !(list_no >= 15 && list_no < 30);
            sink_idles = sender_idles;
            tokens = $urandom_range(1, 5);
            for (int t = 0; t < tokens; t++)
            begin
                if (t != 0)
                    send_item(CHAR_COMMA, 1'b0);
                kind = $urandom_range(0, 99);
                a = pick_line();
                b = pick_line();
                if (kind < 45)
                    send_text(number_text(a));
                else if (kind < 80)
                    send_text({number_text(a), "-", number_text(b)});
                else if (kind < 85)
                    ; // empty token
                else if (kind < 90)
                    send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
                else if (kind < 93)
                    send_text($sformatf("%0d", $urandom_range(1000, 9999)));
                else if (kind < 96)
                    send_text(($urandom_range(0, 1) == 1) ? {"-", number_text(a)}
                                                          : {number_text(a), "--"});
                else
                    send_text({number_text(a), "-"});
            end
            if ($urandom_range(0, 7) == 0)
                send_item(CHAR_COMMA, 1'b0);
            end_list();
            list_no++;
        end
        sender_idles = 1'b1;
        sink_idles = 1'b1;
    endtask

    // Main sequence.
    initial
    begin
        clear_list();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_stall_pressure();
        test_random(550);
        s_axis_tvalid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
